>>> rtl/breaker_operator_interlock_core_defines.svh
// ----------------------------------------------------------------------------
// Breaker operator interlock - assertion macros
// Shared property wrappers, clocked on clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef BREAKER_OPERATOR_INTERLOCK_CORE_DEFINES_SVH
`define BREAKER_OPERATOR_INTERLOCK_CORE_DEFINES_SVH

// same-cycle implication
`define BOI_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define BOI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/boi_pkg.sv
// ----------------------------------------------------------------------------
// boi_pkg
// Item types, configuration layout and fixed constants of the interlock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package boi_pkg;

  localparam int unsigned DEB_W      = 8;   // debounce_ticks / alarm_ticks width
  localparam int unsigned RST_LIM_W  = 11;  // reset_hold_limit width
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned RESET_ARM_TICKS = 10;  // press count must exceed this to arm an alarm reset

  localparam logic [DEB_W-1:0]     DEBOUNCE_RESET = 8'd10;
  localparam logic [DEB_W-1:0]     ALARM_RESET    = 8'd5;
  localparam logic [RST_LIM_W-1:0] HOLD_LIM_RESET = 11'd1000;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [1:0] REG_ALARM_TICKS      = 2'd1;
  localparam logic [1:0] REG_RESET_HOLD_LIMIT = 2'd2;

  typedef struct packed {
    logic lock_closed_pin;
    logic close_cmd_pin;
    logic open_cmd_pin;
    logic stored_pos_pin;
    logic closed_pos_pin;
    logic open_pos_pin;
    logic reset_pin;
    logic protect_off_pin;
    logic external_alarm;
  } in_item_t;

  typedef struct packed {
    logic       close_running;
    logic       open_running;
    logic       charge_running;
    logic [2:0] drive_stop_mask;
    logic       alarm_relay_fire;
    logic       lock_relay_level;
    logic       reset_alarm_request;
    logic       clear_overcurrent;
    logic       run_fault_event;
    logic [2:0] alarm_flags;
    logic       stop_order_request;
  } out_item_t;

  typedef struct packed {
    logic [DEB_W-1:0]     debounce_ticks;
    logic [DEB_W-1:0]     alarm_ticks;
    logic [RST_LIM_W-1:0] reset_hold_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/boi_engine.sv
// ----------------------------------------------------------------------------
// boi_engine
// Interlock state and the per-tick rule chain; state advances on step_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boi_engine #(
  parameter int unsigned CountWidth      = 8,
  parameter int unsigned ResetCountWidth = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire boi_pkg::in_item_t  item_i,
  input  wire boi_pkg::cfg_t      cfg_i,
  output boi_pkg::out_item_t      result_o
);
  import boi_pkg::*;

  localparam int unsigned CW  = CountWidth;
  localparam int unsigned RCW = ResetCountWidth;
  localparam int unsigned CMW = ((CW > DEB_W) ? CW : DEB_W) + 1;
  localparam int unsigned RMW = ((RCW > RST_LIM_W) ? RCW : RST_LIM_W) + 1;
  localparam logic [CW-1:0]  CNT_MAX  = {CW{1'b1}};
  localparam logic [RCW-1:0] RCNT_MAX = {RCW{1'b1}};

  typedef struct packed {
    logic lock_level;
    logic trip_pending;
    logic trip_armed;
    logic rst_armed;
    logic rst_alarm;
    logic pos_alarm;
    logic cmd_alarm;
    logic charge_run;
    logic open_run;
    logic close_run;
  } flags_t;

  function automatic logic [CW-1:0] inc_sat(logic [CW-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // {fired, next count}; count clears on fire or when cond drops
  function automatic logic [CW:0] deb_f(logic [CW-1:0] c, logic cond, logic [DEB_W-1:0] thr);
    logic [CW-1:0] n;
    n = inc_sat(c);
    if (!cond) return {1'b0, {CW{1'b0}}};
    if (CMW'(n) > CMW'(thr)) return {1'b1, {CW{1'b0}}};
    return {1'b0, n};
  endfunction

  function automatic logic idle_f(flags_t fl, logic xa);
    return !fl.close_run && !fl.open_run && !xa && !fl.cmd_alarm && !fl.pos_alarm;
  endfunction

  logic [CW-1:0] close_start_q, close_start_d, charge_start_q, charge_start_d;
  logic [CW-1:0] open_start_q, open_start_d, protect_q, protect_d;
  logic [CW-1:0] cmd_alarm_q, cmd_alarm_d, pos_alarm_q, pos_alarm_d;
  logic [CW-1:0] lock_loss_q, lock_loss_d, close_arrive_q, close_arrive_d;
  logic [CW-1:0] open_arrive_q, open_arrive_d, charge_done_q, charge_done_d;
  logic [CW-1:0] charge_abort_q, charge_abort_d;
  logic [CW-1:0] idle_closed_q, idle_closed_d, idle_open_q, idle_open_d;
  logic [RCW-1:0] press_q, press_d;
  flags_t flags_q, flags_d;

  logic [CW:0]     r_cs, r_ch, r_os, r_pt, r_ca, r_pa, r_ll, r_car, r_oar, r_cd, r_ab;
  logic [RCW-1:0]  press_n;
  logic [RMW-1:0]  press_e, lim_e;
  logic [CMW-1:0]  deb_e;
  logic [CW-1:0]   idle_hold, idle_n;
  logic [2:0]      stop;
  logic            afire, rreq, clroc, rfault, sorder;
  logic            lk, cc, oc, sp, cp, op, rs, pt, xa;
  flags_t          f;

  assign lk = item_i.lock_closed_pin;
  assign cc = item_i.close_cmd_pin;
  assign oc = item_i.open_cmd_pin;
  assign sp = item_i.stored_pos_pin;
  assign cp = item_i.closed_pos_pin;
  assign op = item_i.open_pos_pin;
  assign rs = item_i.reset_pin;
  assign pt = item_i.protect_off_pin;
  assign xa = item_i.external_alarm;

  assign deb_e     = CMW'(cfg_i.debounce_ticks);
  assign idle_hold = (deb_e >= CMW'(CNT_MAX)) ? CNT_MAX : CW'(deb_e + 1'b1);
  assign press_n   = (press_q == RCNT_MAX) ? press_q : press_q + 1'b1;
  assign press_e   = RMW'(press_n);
  assign lim_e     = RMW'(cfg_i.reset_hold_limit);

  always_comb begin
    f              = flags_q;
    close_start_d  = close_start_q;
    charge_start_d = charge_start_q;
    open_start_d   = open_start_q;
    protect_d      = protect_q;
    cmd_alarm_d    = cmd_alarm_q;
    pos_alarm_d    = pos_alarm_q;
    lock_loss_d    = lock_loss_q;
    close_arrive_d = close_arrive_q;
    open_arrive_d  = open_arrive_q;
    charge_done_d  = charge_done_q;
    charge_abort_d = charge_abort_q;
    idle_closed_d  = idle_closed_q;
    idle_open_d    = idle_open_q;
    press_d        = press_q;
    idle_n         = '0;
    stop   = '0;
    afire  = 1'b0;
    rreq   = 1'b0;
    clroc  = 1'b0;
    rfault = 1'b0;
    sorder = 1'b0;
    r_pt   = '0;
    r_ca   = '0;
    r_pa   = '0;
    r_ll   = '0;
    r_car  = '0;
    r_oar  = '0;
    r_cd   = '0;
    r_ab   = '0;

    // start rules
    r_cs = deb_f(close_start_q,
                 !lk && !cc && oc && !sp && cp && !op && rs && idle_f(f, xa),
                 cfg_i.debounce_ticks);
    close_start_d = r_cs[CW-1:0];
    if (r_cs[CW]) f.close_run = 1'b1;

    r_ch = deb_f(charge_start_q,
                 !lk && !cc && oc && sp && cp && !op && rs && idle_f(f, xa),
                 cfg_i.debounce_ticks);
    charge_start_d = r_ch[CW-1:0];
    if (r_ch[CW]) f.charge_run = 1'b1;

    r_os = deb_f(open_start_q, cc && !oc && op && idle_f(f, xa), cfg_i.debounce_ticks);
    open_start_d = r_os[CW-1:0];
    if (r_os[CW]) begin
      f.close_run  = 1'b0;
      f.open_run   = 1'b1;
      f.trip_armed = 1'b0;
    end

    // protective opening
    if (!pt && op && !f.close_run && !f.open_run && !f.pos_alarm) begin
      if (f.trip_armed) begin
        r_pt = deb_f(protect_q, 1'b1, cfg_i.debounce_ticks);
        protect_d = r_pt[CW-1:0];
        if (r_pt[CW]) begin
          f.close_run    = 1'b0;
          f.open_run     = 1'b1;
          f.trip_armed   = 1'b0;
          f.trip_pending = 1'b1;
        end
      end
    end else begin
      protect_d = '0;
      if (pt) f.trip_armed = 1'b1;
    end

    // illegal command / position patterns
    if (!f.close_run && !f.open_run) begin
      r_ca = deb_f(cmd_alarm_q, !cc && !oc, cfg_i.alarm_ticks);
      cmd_alarm_d = r_ca[CW-1:0];
      if (r_ca[CW]) begin
        f.cmd_alarm = 1'b1;
        afire       = 1'b1;
      end else if (cc || oc) begin
        f.cmd_alarm = 1'b0;
      end
      r_pa = deb_f(pos_alarm_q, !cp && !op, cfg_i.alarm_ticks);
      pos_alarm_d = r_pa[CW-1:0];
      if (r_pa[CW]) begin
        f.pos_alarm = 1'b1;
        afire       = 1'b1;
      end else if (cp || op) begin
        f.pos_alarm = 1'b0;
      end
    end

    // reset button
    if (!rs) begin
      press_d = press_n;
      if (press_e > RMW'(RESET_ARM_TICKS) && press_e <= lim_e) begin
        f.rst_armed = 1'b1;
      end else if (press_e > lim_e) begin
        press_d     = (lim_e >= RMW'(RCNT_MAX)) ? RCNT_MAX : RCW'(lim_e + 1'b1);
        f.rst_alarm = 1'b1;
        afire       = 1'b1;
      end
    end else begin
      press_d     = '0;
      f.rst_alarm = 1'b0;
      if (f.rst_armed) begin
        rreq        = 1'b1;
        f.rst_armed = 1'b0;
      end
    end

    // running drives
    if (f.close_run || f.open_run || f.charge_run) begin
      f.lock_level = 1'b0;
      r_ll = deb_f(lock_loss_q, lk && f.close_run, cfg_i.debounce_ticks);
      lock_loss_d = r_ll[CW-1:0];
      if (r_ll[CW]) begin
        f.close_run = 1'b0;
        rfault      = 1'b1;
        stop[0]     = 1'b1;
        sorder      = 1'b1;
      end
      r_car = deb_f(close_arrive_q, !cp && f.close_run, cfg_i.debounce_ticks);
      close_arrive_d = r_car[CW-1:0];
      if (r_car[CW]) begin
        f.close_run = 1'b0;
        stop[0]     = 1'b1;
        if (op) clroc = 1'b1;
        else    rfault = 1'b1;
      end
      r_oar = deb_f(open_arrive_q, !op && f.open_run, cfg_i.debounce_ticks);
      open_arrive_d = r_oar[CW-1:0];
      if (r_oar[CW]) begin
        f.open_run = 1'b0;
        stop[1]    = 1'b1;
        if (cp) begin
          clroc = 1'b1;
          if (f.trip_pending) begin
            f.trip_pending = 1'b0;
            rreq           = 1'b1;
          end
        end else begin
          rfault = 1'b1;
        end
      end
      r_cd = deb_f(charge_done_q, !sp && f.charge_run, cfg_i.debounce_ticks);
      charge_done_d = r_cd[CW-1:0];
      if (r_cd[CW]) begin
        f.charge_run = 1'b0;
        f.close_run  = 1'b1;
        stop[2]      = 1'b1;
      end
      if (f.charge_run) begin
        r_ab = deb_f(charge_abort_q, (!cp && !op) || lk, cfg_i.debounce_ticks);
        charge_abort_d = r_ab[CW-1:0];
        if (r_ab[CW]) begin
          f.charge_run = 1'b0;
          stop[2]      = 1'b1;
          rfault       = 1'b1;
        end
      end
    end else begin
      // idle: lock relay follows the debounced closed contact
      if (!cp) begin
        idle_open_d = '0;
        idle_n      = inc_sat(idle_closed_q);
        if (CMW'(idle_n) > deb_e) begin
          idle_closed_d = idle_hold;
          f.lock_level  = 1'b0;
        end else begin
          idle_closed_d = idle_n;
        end
      end else begin
        idle_closed_d = '0;
        idle_n        = inc_sat(idle_open_q);
        if (CMW'(idle_n) > deb_e) begin
          idle_open_d  = idle_hold;
          f.lock_level = 1'b1;
        end else begin
          idle_open_d = idle_n;
        end
      end
    end

    flags_d = f;

    result_o.close_running       = f.close_run;
    result_o.open_running        = f.open_run;
    result_o.charge_running      = f.charge_run;
    result_o.drive_stop_mask     = stop;
    result_o.alarm_relay_fire    = afire;
    result_o.lock_relay_level    = f.lock_level;
    result_o.reset_alarm_request = rreq;
    result_o.clear_overcurrent   = clroc;
    result_o.run_fault_event     = rfault;
    result_o.alarm_flags         = {f.rst_alarm, f.pos_alarm, f.cmd_alarm};
    result_o.stop_order_request  = sorder;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_start_q  <= '0;
      charge_start_q <= '0;
      open_start_q   <= '0;
      protect_q      <= '0;
      cmd_alarm_q    <= '0;
      pos_alarm_q    <= '0;
      lock_loss_q    <= '0;
      close_arrive_q <= '0;
      open_arrive_q  <= '0;
      charge_done_q  <= '0;
      charge_abort_q <= '0;
      idle_closed_q  <= '0;
      idle_open_q    <= '0;
      press_q        <= '0;
      flags_q        <= '0;
    end else if (step_i) begin
      close_start_q  <= close_start_d;
      charge_start_q <= charge_start_d;
      open_start_q   <= open_start_d;
      protect_q      <= protect_d;
      cmd_alarm_q    <= cmd_alarm_d;
      pos_alarm_q    <= pos_alarm_d;
      lock_loss_q    <= lock_loss_d;
      close_arrive_q <= close_arrive_d;
      open_arrive_q  <= open_arrive_d;
      charge_done_q  <= charge_done_d;
      charge_abort_q <= charge_abort_d;
      idle_closed_q  <= idle_closed_d;
      idle_open_q    <= idle_open_d;
      press_q        <= press_d;
      flags_q        <= flags_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/breaker_operator_interlock_core.sv
// ----------------------------------------------------------------------------
// breaker_operator_interlock_core
// Breaker operator interlock: one 2 ms tick of pin levels in, one status out.
// ----------------------------------------------------------------------------
// Each accepted item is one tick of the eight operator pins plus the external
// alarm bit; each tick produces exactly one result item in the same order.
// An item lands in an input register, the rule chain evaluates it
// combinationally against the debounce counters and run flags, and the result
// lands in an output register, so a result passes the input register and then
// the output register; a new item is taken every cycle (one item per clock)
// while the output is not stalled. If the output is stalled, one
// more item is held in the input register before in_ready_o drops. Three
// configuration registers sit on the APB port at 0x0 (debounce_ticks), 0x4
// (alarm_ticks) and 0x8 (reset_hold_limit); they reset to 10, 5 and 1000 and
// should only be written while no item is in flight. All counters and flags
// clear on reset.
`timescale 1ns / 1ps
`default_nettype none
`include "breaker_operator_interlock_core_defines.svh"

module breaker_operator_interlock_core #(
  parameter int unsigned COUNT_WIDTH       = 8,
  parameter int unsigned RESET_COUNT_WIDTH = 11
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // tick items
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire boi_pkg::in_item_t                     in_item_i,
  // result items
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output boi_pkg::out_item_t                         out_item_o,
  // APB configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [boi_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire logic [boi_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [boi_pkg::CFG_DATA_W-1:0]             prdata,
  output logic                                       pready
);
  import boi_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEBOUNCE_RESET;
      cfg_q.alarm_ticks      <= ALARM_RESET;
      cfg_q.reset_hold_limit <= HOLD_LIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= pwdata[DEB_W-1:0];
        REG_ALARM_TICKS:      cfg_q.alarm_ticks      <= pwdata[DEB_W-1:0];
        REG_RESET_HOLD_LIMIT: cfg_q.reset_hold_limit <= pwdata[RST_LIM_W-1:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE_TICKS:   prdata = CFG_DATA_W'(cfg_q.debounce_ticks);
      REG_ALARM_TICKS:      prdata = CFG_DATA_W'(cfg_q.alarm_ticks);
      REG_RESET_HOLD_LIMIT: prdata = CFG_DATA_W'(cfg_q.reset_hold_limit);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item pipeline: input register -> rule chain -> output register
  // --------------------------------------------------------------------------
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  logic      advance;
  logic      in_take;

  // the held tick moves on whenever the output slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take)      in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_item_i;
    if (advance) out_q <= result;
  end

  // interlock state only moves when a tick is handed to the output register
  boi_engine #(
    .CountWidth      (COUNT_WIDTH),
    .ResetCountWidth (RESET_COUNT_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input stage only blocks when its tick is stuck behind a stalled result
  `BOI_ASSERT_IMPL(a_ready_only_on_stall, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i)
  // a held tick keeps its payload until it advances
  `BOI_ASSERT_NEXT(a_held_tick_stable, in_valid_q && !advance, in_valid_q && $stable(in_q))
  // a stop order only comes from a lock loss, which stops close and faults
  `BOI_ASSERT_IMPL(a_stop_order_fault, out_valid_o && out_item_o.stop_order_request,
                   out_item_o.run_fault_event && out_item_o.drive_stop_mask[0])
  // overcurrent clear only on an arrival, which always stops a drive
  `BOI_ASSERT_IMPL(a_clear_on_arrival, out_valid_o && out_item_o.clear_overcurrent,
                   out_item_o.drive_stop_mask[0] || out_item_o.drive_stop_mask[1])

endmodule

`default_nettype wire
